// ===== rtl/afd_pkg.sv =====
`timescale 1ns / 1ps
package afd_pkg;

	localparam int WORD_W          = 16;
	localparam int SAMPLE_W        = 12;
	localparam int MAX_CAL_SAMPLES = 512;
	localparam int CNT_W           = $clog2(MAX_CAL_SAMPLES + 1);
	localparam int SUM_W           = SAMPLE_W + CNT_W;
	localparam int PROD_W          = SAMPLE_W + CNT_W + 1;
	localparam int DIFF_W          = PROD_W + 1;
	localparam int SQ_W            = 2 * DIFF_W;
	localparam int ERR_W           = SQ_W + 2;
	localparam int NUM_AXES        = 3;

	localparam logic [WORD_W-1:0] MARKER_BIT = 16'h0001;

	localparam int NUM_REGS  = 3;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_REF_X = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_REF_Y = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_REF_Z = 2'd2;

	localparam logic OP_DECODE = 1'b0;
	localparam logic OP_CAL    = 1'b1;

	localparam int AXIS_X = 0;
	localparam int AXIS_Y = 1;
	localparam int AXIS_Z = 2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [SQ_W-1:0] sq_t;
	typedef sq_t [NUM_AXES-1:0] sq_vec_t;

	typedef enum logic [1:0] {
		ORD_XYZ = 2'd0,
		ORD_YZX = 2'd1,
		ORD_ZXY = 2'd2
	} order_t;

	typedef struct packed {
		logic acc_en;
		logic clr;
		logic mul_en;
		logic sq_en;
		logic err_en;
	} lane_ctl_t;

endpackage

// ===== rtl/afd_in_if.sv =====
`timescale 1ns / 1ps
interface afd_in_if;
	import afd_pkg::*;
	logic              valid;
	logic              ready;
	logic              op;
	logic [WORD_W-1:0] word_a;
	logic [WORD_W-1:0] word_b;
	logic [WORD_W-1:0] word_c;
	logic              last;
	modport source(output valid, op, word_a, word_b, word_c, last, input ready);
	modport sink(input valid, op, word_a, word_b, word_c, last, output ready);
endinterface

// ===== rtl/afd_out_if.sv =====
`timescale 1ns / 1ps
interface afd_out_if;
	import afd_pkg::*;
	logic       valid;
	logic       ready;
	sample_t    accel_x;
	sample_t    accel_y;
	sample_t    accel_z;
	logic       frame_error;
	logic [1:0] axis_order;
	logic       order_known;
	logic       order_decided;
	modport source(output valid, accel_x, accel_y, accel_z, frame_error, axis_order,
		order_known, order_decided, input ready);
	modport sink(input valid, accel_x, accel_y, accel_z, frame_error, axis_order,
		order_known, order_decided, output ready);
endinterface

// ===== rtl/afd_cfg_if.sv =====
`timescale 1ns / 1ps
interface afd_cfg_if;
	import afd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] idx;
	logic [SAMPLE_W-1:0]  data;
	modport source(output valid, idx, data, input ready);
	modport sink(input valid, idx, data, output ready);
endinterface

// ===== rtl/afd_lane.sv =====
`timescale 1ns / 1ps
module afd_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [afd_pkg::WORD_W-1:0] word,
	input  afd_pkg::lane_ctl_t    ctl,
	input  logic [afd_pkg::CNT_W-1:0]  count,
	input  afd_pkg::sample_t      ref_x,
	input  afd_pkg::sample_t      ref_y,
	input  afd_pkg::sample_t      ref_z,
	output afd_pkg::sample_t      sample,
	output logic                  marker,
	output afd_pkg::sq_vec_t      sq
);
	import afd_pkg::*;

	logic signed [SUM_W-1:0]  sum_q;
	logic signed [CNT_W:0]    n_s;
	logic signed [PROD_W-1:0] prod_s1 [NUM_AXES];
	logic signed [DIFF_W-1:0] diff [NUM_AXES];
	logic signed [SQ_W-1:0]   sq_c [NUM_AXES];
	sq_t                      sq_s2 [NUM_AXES];

	assign sample = sample_t'(word[WORD_W-1 -: SAMPLE_W]);
	assign marker = |(word & MARKER_BIT);
	assign n_s    = {1'b0, count};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.clr) begin
			sum_q <= '0;
		end else if (ctl.acc_en) begin
			sum_q <= sum_q + SUM_W'(sample);
		end
	end

	// n * ref for each axis
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1[AXIS_X] <= n_s * ref_x;
			prod_s1[AXIS_Y] <= n_s * ref_y;
			prod_s1[AXIS_Z] <= n_s * ref_z;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			diff[i] = DIFF_W'(sum_q) - DIFF_W'(prod_s1[i]);
			sq_c[i] = diff[i] * diff[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sq_en) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				sq_s2[i] <= sq_t'(sq_c[i]);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			sq[i] = sq_s2[i];
		end
	end

endmodule

// ===== rtl/afd_merge.sv =====
`timescale 1ns / 1ps
module afd_merge (
	input  logic               clk,
	input  afd_pkg::lane_ctl_t ctl,
	input  afd_pkg::sq_vec_t   sq_a,
	input  afd_pkg::sq_vec_t   sq_b,
	input  afd_pkg::sq_vec_t   sq_c,
	output afd_pkg::order_t    best
);
	import afd_pkg::*;

	logic [ERR_W-1:0] e_xyz_s3;
	logic [ERR_W-1:0] e_yzx_s3;
	logic [ERR_W-1:0] e_zxy_s3;

	// each order maps slots a/b/c onto axes differently
	always_ff @(posedge clk) begin
		if (ctl.err_en) begin
			e_xyz_s3 <= ERR_W'(sq_a[AXIS_X]) + ERR_W'(sq_b[AXIS_Y]) + ERR_W'(sq_c[AXIS_Z]);
			e_yzx_s3 <= ERR_W'(sq_c[AXIS_X]) + ERR_W'(sq_a[AXIS_Y]) + ERR_W'(sq_b[AXIS_Z]);
			e_zxy_s3 <= ERR_W'(sq_b[AXIS_X]) + ERR_W'(sq_c[AXIS_Y]) + ERR_W'(sq_a[AXIS_Z]);
		end
	end

	// ties fall back to xyz, yzx beats zxy on equality
	always_comb begin
		if (e_yzx_s3 < e_xyz_s3 && e_yzx_s3 <= e_zxy_s3) begin
			best = ORD_YZX;
		end else if (e_zxy_s3 < e_xyz_s3 && e_zxy_s3 < e_yzx_s3) begin
			best = ORD_ZXY;
		end else begin
			best = ORD_XYZ;
		end
	end

endmodule

// ===== rtl/accel_fifo_triplet_decoder_axis_detect_top.sv =====
`timescale 1ns / 1ps
// accelerometer fifo frame decoder with axis-order detection
// in_ch: one beat is a frame of three raw words (word_a..word_c) plus op and last.
//   op decode: samples are permuted by the stored axis order and sent as x, y, z.
//   op calibrate: slot samples are summed; last starts the order decision.
// out_ch: one result beat per input beat, from an output register, at the earliest in
//   the cycle after the input beat.
// cfg: writes ref_x/ref_y/ref_z by index, always ready; a write to any of these three
//   clears the order to xyz and marks it unknown. write only while the block is idle.
// throughput: decode and ordinary calibrate beats go one per cycle while out_ch does
//   not stall. a calibrate beat with last runs the states mul, sq, sum and cmp: the
//   three slot lanes form n*ref and square the distances, the merge stage sums the
//   three candidate errors and compares them; no input is taken meanwhile.
// reset clears the sums, count, and output valid; order is xyz and known,
//   references are zero.
// when out_ch stalls the result waits in the output register and in_ch ready drops
//   until it is taken or taken in the same cycle.
module accel_fifo_triplet_decoder_axis_detect_top (
	input  logic      clk,
	input  logic      arst_n,
	afd_in_if.sink    in_ch,
	afd_out_if.source out_ch,
	afd_cfg_if.sink   cfg
);
	import afd_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_SQ   = 5'b00100,
		ST_SUM  = 5'b01000,
		ST_CMP  = 5'b10000
	} state_t;

	state_t           state_q;
	lane_ctl_t        ctl;
	logic [CNT_W-1:0] count_q;
	order_t           order_q;
	logic             known_q;
	sample_t          ref_x_q;
	sample_t          ref_y_q;
	sample_t          ref_z_q;
	logic             err_q;

	sample_t          s_a, s_b, s_c;
	logic             m_a, m_b, m_c;
	sq_vec_t          sq_a, sq_b, sq_c;
	order_t           best;

	logic             out_valid_q;
	sample_t          ax_q, ay_q, az_q;
	logic             ferr_q;
	logic [1:0]       ord_out_q;
	logic             known_out_q;
	logic             decided_q;

	logic             out_free;
	logic             in_fire;
	logic             cfg_fire;
	logic             frame_err;
	logic             is_cal;
	logic             room;
	logic             start_dec;
	logic             cmp_done;
	logic             load_item;
	sample_t          px, py, pz;

	assign out_free  = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && out_free;
	assign in_fire   = in_ch.valid && in_ch.ready;
	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;

	assign frame_err = !m_a || m_b || m_c;
	assign is_cal    = (in_ch.op == OP_CAL);
	assign room      = count_q < CNT_W'(MAX_CAL_SAMPLES);
	assign start_dec = in_fire && is_cal && in_ch.last;
	assign load_item = in_fire && !start_dec;
	assign cmp_done  = (state_q == ST_CMP) && out_free;

	assign ctl.acc_en = in_fire && is_cal && room;
	assign ctl.clr    = cmp_done;
	assign ctl.mul_en = (state_q == ST_MUL);
	assign ctl.sq_en  = (state_q == ST_SQ);
	assign ctl.err_en = (state_q == ST_SUM);

	afd_lane u_lane_a (
		.clk(clk), .arst_n(arst_n), .word(in_ch.word_a), .ctl(ctl), .count(count_q),
		.ref_x(ref_x_q), .ref_y(ref_y_q), .ref_z(ref_z_q),
		.sample(s_a), .marker(m_a), .sq(sq_a)
	);

	afd_lane u_lane_b (
		.clk(clk), .arst_n(arst_n), .word(in_ch.word_b), .ctl(ctl), .count(count_q),
		.ref_x(ref_x_q), .ref_y(ref_y_q), .ref_z(ref_z_q),
		.sample(s_b), .marker(m_b), .sq(sq_b)
	);

	afd_lane u_lane_c (
		.clk(clk), .arst_n(arst_n), .word(in_ch.word_c), .ctl(ctl), .count(count_q),
		.ref_x(ref_x_q), .ref_y(ref_y_q), .ref_z(ref_z_q),
		.sample(s_c), .marker(m_c), .sq(sq_c)
	);

	afd_merge u_merge (
		.clk(clk), .ctl(ctl), .sq_a(sq_a), .sq_b(sq_b), .sq_c(sq_c), .best(best)
	);

	// slot permutation, identity when the order is unknown
	always_comb begin
		px = s_a;
		py = s_b;
		pz = s_c;
		if (known_q) begin
			case (order_q)
				ORD_YZX: begin
					px = s_c;
					py = s_a;
					pz = s_b;
				end
				ORD_ZXY: begin
					px = s_b;
					py = s_c;
					pz = s_a;
				end
				default: begin
					px = s_a;
					py = s_b;
					pz = s_c;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (start_dec) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_CMP;
				ST_CMP:  if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			order_q <= ORD_XYZ;
			known_q <= 1'b1;
			ref_x_q <= '0;
			ref_y_q <= '0;
			ref_z_q <= '0;
		end else begin
			if (ctl.acc_en) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cfg_fire) begin
				case (cfg.idx)
					REG_REF_X: begin
						ref_x_q <= sample_t'(cfg.data);
						order_q <= ORD_XYZ;
						known_q <= 1'b0;
					end
					REG_REF_Y: begin
						ref_y_q <= sample_t'(cfg.data);
						order_q <= ORD_XYZ;
						known_q <= 1'b0;
					end
					REG_REF_Z: begin
						ref_z_q <= sample_t'(cfg.data);
						order_q <= ORD_XYZ;
						known_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (cmp_done) begin
				count_q <= '0;
				order_q <= best;
				known_q <= 1'b1;
			end
		end
	end

	// frame error of the deciding beat is held until its result goes out
	always_ff @(posedge clk) begin
		if (start_dec) begin
			err_q <= frame_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_item || cmp_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_item) begin
			if (!is_cal && !frame_err) begin
				ax_q <= px;
				ay_q <= py;
				az_q <= pz;
			end else begin
				ax_q <= '0;
				ay_q <= '0;
				az_q <= '0;
			end
			ferr_q      <= frame_err;
			ord_out_q   <= order_q;
			known_out_q <= known_q;
			decided_q   <= 1'b0;
		end else if (cmp_done) begin
			ax_q        <= '0;
			ay_q        <= '0;
			az_q        <= '0;
			ferr_q      <= err_q;
			ord_out_q   <= best;
			known_out_q <= 1'b1;
			decided_q   <= 1'b1;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.accel_x       = ax_q;
	assign out_ch.accel_y       = ay_q;
	assign out_ch.accel_z       = az_q;
	assign out_ch.frame_error   = ferr_q;
	assign out_ch.axis_order    = ord_out_q;
	assign out_ch.order_known   = known_out_q;
	assign out_ch.order_decided = decided_q;

endmodule

// ===== sim/accel_fifo_triplet_decoder_axis_detect_top_test.sv =====
`timescale 1ns / 1ps
module accel_fifo_triplet_decoder_axis_detect_top_test;
	import afd_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 360;

	typedef struct packed {
		logic              op;
		logic [WORD_W-1:0] wa;
		logic [WORD_W-1:0] wb;
		logic [WORD_W-1:0] wc;
		logic              last;
	} frame_t;

	typedef struct packed {
		sample_t    ax;
		sample_t    ay;
		sample_t    az;
		logic       err;
		logic [1:0] order;
		logic       known;
		logic       decided;
	} axis_beat_t;

	typedef struct {
		logic                 is_cfg;
		logic [REG_IDX_W-1:0] idx;
		sample_t              data;
		frame_t               fr;
		logic                 pinned;
		axis_beat_t           want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	afd_in_if  in_ch();
	afd_out_if out_ch();
	afd_cfg_if cfg_bus();

	accel_fifo_triplet_decoder_axis_detect_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_bus)
	);

	always #10 clk = ~clk;

	// shadow of the block state
	sample_t ref_axis [NUM_AXES];
	longint  slot_acc [NUM_AXES];
	int      cal_n;
	order_t  cur_order;
	logic    order_ok;

	axis_beat_t due_beats [$];
	plan_row_t  plan [$];
	int errors = 0;
	int beats_seen = 0;
	int items_sent = 0;
	int cycles = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int stall_left = 0;

	function automatic longint order_err(longint s0, longint s1, longint s2, longint n);
		longint d0, d1, d2;
		d0 = s0 - n * ref_axis[AXIS_X];
		d1 = s1 - n * ref_axis[AXIS_Y];
		d2 = s2 - n * ref_axis[AXIS_Z];
		return d0 * d0 + d1 * d1 + d2 * d2;
	endfunction

	function automatic axis_beat_t decode_and_detect(frame_t f);
		sample_t    s [NUM_AXES];
		longint     n, e_xyz, e_yzx, e_zxy;
		axis_beat_t r;
		s[0] = f.wa[WORD_W-1:4];
		s[1] = f.wb[WORD_W-1:4];
		s[2] = f.wc[WORD_W-1:4];
		r = '0;
		r.err = !f.wa[0] || f.wb[0] || f.wc[0];
		if (f.op == OP_DECODE) begin
			if (!r.err) begin
				if (order_ok && cur_order == ORD_YZX) begin
					r.ax = s[2]; r.ay = s[0]; r.az = s[1];
				end else if (order_ok && cur_order == ORD_ZXY) begin
					r.ax = s[1]; r.ay = s[2]; r.az = s[0];
				end else begin
					r.ax = s[0]; r.ay = s[1]; r.az = s[2];
				end
			end
		end else begin
			if (cal_n < MAX_CAL_SAMPLES) begin
				for (int i = 0; i < NUM_AXES; i++)
					slot_acc[i] += s[i];
				cal_n++;
			end
			if (f.last) begin
				n = cal_n;
				e_xyz = order_err(slot_acc[0], slot_acc[1], slot_acc[2], n);
				e_yzx = order_err(slot_acc[2], slot_acc[0], slot_acc[1], n);
				e_zxy = order_err(slot_acc[1], slot_acc[2], slot_acc[0], n);
				// ties fall back to xyz, yzx beats zxy on equal error
				if (e_yzx < e_xyz && e_yzx <= e_zxy)
					cur_order = ORD_YZX;
				else if (e_zxy < e_xyz && e_zxy < e_yzx)
					cur_order = ORD_ZXY;
				else
					cur_order = ORD_XYZ;
				order_ok = 1'b1;
				for (int i = 0; i < NUM_AXES; i++)
					slot_acc[i] = 0;
				cal_n = 0;
				r.decided = 1'b1;
			end
		end
		r.order = cur_order;
		r.known = order_ok;
		return r;
	endfunction

	function automatic plan_row_t row_frame(logic op, logic [WORD_W-1:0] wa,
		logic [WORD_W-1:0] wb, logic [WORD_W-1:0] wc, logic last);
		plan_row_t r;
		r.is_cfg = 1'b0;
		r.idx = REG_REF_X;
		r.data = '0;
		r.fr = '{op: op, wa: wa, wb: wb, wc: wc, last: last};
		r.pinned = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic plan_row_t row_pin(logic op, logic [WORD_W-1:0] wa,
		logic [WORD_W-1:0] wb, logic [WORD_W-1:0] wc, logic last,
		int ax, int ay, int az, logic err, order_t ord, logic known, logic dec);
		plan_row_t r;
		r = row_frame(op, wa, wb, wc, last);
		r.pinned = 1'b1;
		r.want.ax = ax[SAMPLE_W-1:0];
		r.want.ay = ay[SAMPLE_W-1:0];
		r.want.az = az[SAMPLE_W-1:0];
		r.want.err = err;
		r.want.order = ord;
		r.want.known = known;
		r.want.decided = dec;
		return r;
	endfunction

	function automatic plan_row_t row_cfg(logic [REG_IDX_W-1:0] idx, int val);
		plan_row_t r;
		r = row_frame(OP_DECODE, '0, '0, '0, 1'b0);
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = val[SAMPLE_W-1:0];
		return r;
	endfunction

	function automatic int pick_idle(int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		return ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
	endfunction

	function automatic sample_t near(sample_t v, int spread);
		int t;
		t = int'(v) + int'($urandom_range(2 * spread)) - spread;
		if (t > 2047)
			t = 2047;
		if (t < -2048)
			t = -2048;
		return t[SAMPLE_W-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] pack_word(sample_t s, logic mark);
		logic [2:0] pad;
		pad = 3'($urandom_range(7));
		return {s, pad, mark};
	endfunction

	task automatic report_mismatch(string msg);
		errors++;
		$display("[beat %0d] %s", beats_seen, msg);
	endtask

	task automatic check_field(string name, integer got, integer want);
		if (got !== want)
			report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
	endtask

	// drop valid and wait until every queued beat has come back
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (due_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_ref(logic [REG_IDX_W-1:0] idx, sample_t val);
		settle();
		cfg_bus.valid <= 1'b1;
		cfg_bus.idx   <= idx;
		cfg_bus.data  <= val;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		cfg_bus.valid <= 1'b0;
		ref_axis[idx] = val;
		cur_order = ORD_XYZ;
		order_ok = 1'b0;
	endtask

	task automatic send_frame(frame_t f, logic pinned, axis_beat_t want);
		int         gap;
		axis_beat_t pred;
		gap = pick_idle(gap_pct);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.op     <= f.op;
		in_ch.word_a <= f.wa;
		in_ch.word_b <= f.wb;
		in_ch.word_c <= f.wc;
		in_ch.last   <= f.last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		pred = decode_and_detect(f);
		due_beats.push_back(pinned ? want : pred);
		items_sent++;
	endtask

	// calibration frames that follow the references in some slot order
	task automatic cal_run(int len);
		int      perm, spread, flip;
		sample_t s [NUM_AXES];
		logic    mk [NUM_AXES];
		frame_t  f;
		perm = $urandom_range(2);
		spread = ($urandom_range(3) == 0) ? 600 : 16;
		for (int k = 0; k < len; k++) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				s[i] = near(ref_axis[(i + perm) % NUM_AXES], spread);
				mk[i] = (i == 0);
			end
			if ($urandom_range(19) == 0) begin
				flip = $urandom_range(2);
				mk[flip] = !mk[flip];
			end
			f.op = OP_CAL;
			f.wa = pack_word(s[0], mk[0]);
			f.wb = pack_word(s[1], mk[1]);
			f.wc = pack_word(s[2], mk[2]);
			f.last = (k == len - 1);
			send_frame(f, 1'b0, '0);
		end
	endtask

	task automatic decode_run(int len);
		frame_t f;
		for (int k = 0; k < len; k++) begin
			f.op = OP_DECODE;
			f.wa = pack_word(sample_t'($urandom_range(4095)), 1'b1);
			f.wb = pack_word(sample_t'($urandom_range(4095)), 1'b0);
			f.wc = pack_word(sample_t'($urandom_range(4095)), 1'b0);
			if ($urandom_range(9) == 0)
				f.wb[0] = 1'b1;
			f.last = 1'($urandom_range(1));
			send_frame(f, 1'b0, '0);
		end
	endtask

	task automatic noise_run(int len);
		frame_t f;
		for (int k = 0; k < len; k++) begin
			f.op = 1'($urandom_range(1));
			f.wa = WORD_W'($urandom_range(16'hFFFF));
			f.wb = WORD_W'($urandom_range(16'hFFFF));
			f.wc = WORD_W'($urandom_range(16'hFFFF));
			f.last = 1'($urandom_range(1));
			send_frame(f, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		axis_beat_t w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			beats_seen++;
			if (due_beats.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				w = due_beats.pop_front();
				check_field("accel_x", out_ch.accel_x, w.ax);
				check_field("accel_y", out_ch.accel_y, w.ay);
				check_field("accel_z", out_ch.accel_z, w.az);
				check_field("frame_error", out_ch.frame_error, w.err);
				check_field("axis_order", out_ch.axis_order, w.order);
				check_field("order_known", out_ch.order_known, w.known);
				check_field("order_decided", out_ch.order_decided, w.decided);
			end
		end
		if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			out_ch.ready <= 1'b1;
			stall_left = pick_idle(stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		in_ch.valid   = 1'b0;
		in_ch.op      = OP_DECODE;
		in_ch.word_a  = '0;
		in_ch.word_b  = '0;
		in_ch.word_c  = '0;
		in_ch.last    = 1'b0;
		out_ch.ready  = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.idx   = REG_REF_X;
		cfg_bus.data  = '0;
		for (int i = 0; i < NUM_AXES; i++) begin
			ref_axis[i] = '0;
			slot_acc[i] = 0;
		end
		cal_n = 0;
		cur_order = ORD_XYZ;
		order_ok = 1'b1;

		// markers, extremes and the reset order
		plan.push_back(row_pin(OP_DECODE, 16'h0001, 16'h0000, 16'h0000, 1'b0,
			0, 0, 0, 1'b0, ORD_XYZ, 1'b1, 1'b0));
		plan.push_back(row_pin(OP_DECODE, 16'h7FF1, 16'h7FF0, 16'h8000, 1'b0,
			2047, 2047, -2048, 1'b0, ORD_XYZ, 1'b1, 1'b0));
		plan.push_back(row_pin(OP_DECODE, 16'hFFFF, 16'hFFFE, 16'hFFFE, 1'b0,
			-1, -1, -1, 1'b0, ORD_XYZ, 1'b1, 1'b0));
		plan.push_back(row_pin(OP_DECODE, 16'h0000, 16'h0000, 16'h0000, 1'b0,
			0, 0, 0, 1'b1, ORD_XYZ, 1'b1, 1'b0));
		plan.push_back(row_pin(OP_DECODE, 16'h7FF1, 16'h7FF1, 16'h7FF0, 1'b0,
			0, 0, 0, 1'b1, ORD_XYZ, 1'b1, 1'b0));
		plan.push_back(row_pin(OP_DECODE, 16'h8001, 16'h8000, 16'h8001, 1'b0,
			0, 0, 0, 1'b1, ORD_XYZ, 1'b1, 1'b0));
		// last is ignored when decoding
		plan.push_back(row_pin(OP_DECODE, 16'h1231, 16'h4560, 16'h7890, 1'b1,
			291, 1110, 1929, 1'b0, ORD_XYZ, 1'b1, 1'b0));
		// zero references: every order ties, xyz kept
		plan.push_back(row_pin(OP_CAL, 16'h0001, 16'h0000, 16'h0000, 1'b1,
			0, 0, 0, 1'b0, ORD_XYZ, 1'b1, 1'b1));
		plan.push_back(row_cfg(REG_REF_X, 100));
		// order unknown after a write: identity order
		plan.push_back(row_pin(OP_DECODE, 16'h0011, 16'h0020, 16'h0030, 1'b0,
			1, 2, 3, 1'b0, ORD_XYZ, 1'b0, 1'b0));
		plan.push_back(row_pin(OP_CAL, 16'h0001, 16'h0000, 16'h0640, 1'b1,
			0, 0, 0, 1'b0, ORD_YZX, 1'b1, 1'b1));
		plan.push_back(row_pin(OP_DECODE, 16'h0011, 16'h0020, 16'h0030, 1'b0,
			3, 1, 2, 1'b0, ORD_YZX, 1'b1, 1'b0));
		// yzx and zxy tie below xyz: yzx wins
		plan.push_back(row_pin(OP_CAL, 16'h0001, 16'h0640, 16'h0640, 1'b1,
			0, 0, 0, 1'b0, ORD_YZX, 1'b1, 1'b1));
		plan.push_back(row_pin(OP_CAL, 16'h0001, 16'h0640, 16'h0000, 1'b1,
			0, 0, 0, 1'b0, ORD_ZXY, 1'b1, 1'b1));
		plan.push_back(row_pin(OP_DECODE, 16'h0011, 16'h0020, 16'h0030, 1'b0,
			2, 3, 1, 1'b0, ORD_ZXY, 1'b1, 1'b0));
		// bad markers in calibration still get summed
		plan.push_back(row_pin(OP_CAL, 16'h0000, 16'h0641, 16'h0000, 1'b0,
			0, 0, 0, 1'b1, ORD_ZXY, 1'b1, 1'b0));
		plan.push_back(row_frame(OP_CAL, 16'h0001, 16'h0640, 16'h0000, 1'b1));
		plan.push_back(row_cfg(REG_REF_X, -2048));
		plan.push_back(row_cfg(REG_REF_Y, 2047));
		plan.push_back(row_cfg(REG_REF_Z, -2048));
		plan.push_back(row_frame(OP_DECODE, 16'h8001, 16'h7FF0, 16'h8000, 1'b0));
		plan.push_back(row_frame(OP_CAL, 16'h8001, 16'h8000, 16'h7FF0, 1'b0));
		plan.push_back(row_frame(OP_CAL, 16'h7FFF, 16'h800E, 16'h7FFE, 1'b0));
		plan.push_back(row_frame(OP_CAL, 16'h8001, 16'h7FF0, 16'h8000, 1'b1));
		plan.push_back(row_frame(OP_CAL, 16'h0000, 16'h0000, 16'h0001, 1'b1));
		plan.push_back(row_frame(OP_DECODE, 16'h7FF1, 16'h8000, 16'h7FF0, 1'b0));
		plan.push_back(row_cfg(REG_REF_Z, 2047));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 30;
		stall_pct = 30;
		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_ref(plan[i].idx, plan[i].data);
			else
				send_frame(plan[i].fr, plan[i].pinned, plan[i].want);
		end

		while (items_sent < plan.size() + RANDOM_ITEMS) begin
			case ($urandom_range(3))
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 20; stall_pct = 20; end
				2: begin gap_pct = 50; stall_pct = 10; end
				default: begin gap_pct = 10; stall_pct = 50; end
			endcase
			if ($urandom_range(2) == 0) begin
				repeat ($urandom_range(3, 1)) begin
					case ($urandom_range(4))
						0: write_ref(REG_IDX_W'($urandom_range(2)), -12'sd2048);
						1: write_ref(REG_IDX_W'($urandom_range(2)), 12'sd2047);
						default: write_ref(REG_IDX_W'($urandom_range(2)),
							sample_t'($urandom_range(4095)));
					endcase
				end
			end
			repeat ($urandom_range(6, 2)) begin
				case ($urandom_range(9))
					6, 7: decode_run($urandom_range(8, 1));
					8, 9: noise_run($urandom_range(6, 1));
					default: begin
						cal_run(($urandom_range(3) == 0) ? 1 : $urandom_range(12, 2));
						decode_run($urandom_range(8, 1));
					end
				endcase
			end
			if ($urandom_range(3) == 0)
				settle();
		end

		settle();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/afd_pkg.sv
rtl/afd_in_if.sv
rtl/afd_out_if.sv
rtl/afd_cfg_if.sv
rtl/afd_lane.sv
rtl/afd_merge.sv
rtl/accel_fifo_triplet_decoder_axis_detect_top.sv
sim/accel_fifo_triplet_decoder_axis_detect_top_test.sv
